// ----- rtl/lidl_pkg.sv -----
// Package for the link idle detector: widths, codes, shared types and helpers.
// No dependencies; every other file imports this one.
`timescale 1ns / 1ps

package lidl_pkg;

  localparam int TIME_W   = 32;                           // idle-time counter width, 8..64
  localparam int THRESH_W = 32;                           // threshold / count width
  localparam int CMP_W    = (TIME_W > THRESH_W) ? TIME_W : THRESH_W;
  localparam int NKIND    = 3;
  localparam int IDX_W    = 2;
  localparam int KIND_W   = 2;

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_READ       = 3'd1,
    ACT_WRITE_DONE = 3'd2,
    ACT_ACTIVATE   = 3'd3,
    ACT_DEACTIVATE = 3'd4
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_READER = 2'd0,
    KIND_WRITER = 2'd1,
    KIND_ALL    = 2'd2
  } kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_READER_IDLE = 2'd0,
    REG_WRITER_IDLE = 2'd1,
    REG_ALL_IDLE    = 2'd2
  } reg_idx_t;

  // control strobes from the top level into each timer
  typedef struct packed {
    logic tick;
    logic arm;
    logic disarm;
    logic clr_count;
    logic chan_open;
  } tmr_ctl_t;

  // what one timer raises on a tick
  typedef struct packed {
    logic                fire;
    logic [THRESH_W-1:0] count;
    logic [THRESH_W-1:0] idle_time;
  } tmr_evt_t;

  typedef struct packed {
    kind_t               kind;
    logic [THRESH_W-1:0] count;
    logic [THRESH_W-1:0] idle_time;
  } evt_beat_t;

  function automatic logic [THRESH_W-1:0] sat_out(input logic [CMP_W-1:0] v);
    if ((v >> THRESH_W) != '0) return '1;
    return THRESH_W'(v);
  endfunction

endpackage

// ----- rtl/lidl_timer.sv -----
// One idle timer: countdown, armed flag and saturating event count.
// Depends on lidl_pkg.
`timescale 1ns / 1ps

module lidl_timer
  import lidl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  tmr_ctl_t            ctl,
  input  logic [THRESH_W-1:0] thresh,
  input  logic [CMP_W-1:0]    elapsed,   // idle time after this tick's increment
  output tmr_evt_t            evt
);

  logic                armed_r, armed_nxt;
  logic [THRESH_W-1:0] cdown_r, cdown_nxt;
  logic [THRESH_W-1:0] count_r, count_nxt;
  logic [CMP_W-1:0]    thresh_w;
  logic                reached;

  assign thresh_w = CMP_W'(thresh);
  assign reached  = (elapsed >= thresh_w);

  always_comb begin
    armed_nxt = armed_r;
    cdown_nxt = cdown_r;
    count_nxt = count_r;
    evt.fire      = 1'b0;
    evt.count     = count_r;
    evt.idle_time = sat_out(elapsed);
    if (ctl.clr_count) begin
      count_nxt = '0;
    end
    if (ctl.arm && (thresh != '0)) begin
      armed_nxt = 1'b1;
      cdown_nxt = thresh;
    end
    if (ctl.disarm) begin
      armed_nxt = 1'b0;
    end
    if (ctl.tick && armed_r) begin
      if (cdown_r > THRESH_W'(1)) begin
        cdown_nxt = cdown_r - THRESH_W'(1);
      end else if (!ctl.chan_open || (thresh == '0)) begin
        cdown_nxt = '0;
        armed_nxt = 1'b0;
      end else if (reached) begin
        evt.fire  = 1'b1;
        cdown_nxt = thresh;
        if (count_r != '1) count_nxt = count_r + THRESH_W'(1);
      end else begin
        // re-arm for what is left of the threshold
        cdown_nxt = THRESH_W'(thresh_w - elapsed);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      cdown_r <= '0;
      count_r <= '0;
    end else begin
      armed_r <= armed_nxt;
      cdown_r <= cdown_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/lidl_evbuf.sv -----
// Result buffer: holds one tick's events, hands out one beat a cycle while popped.
// Depends on lidl_pkg.
`timescale 1ns / 1ps

module lidl_evbuf
  import lidl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  tmr_evt_t  evt [NKIND],
  input  logic      pop,
  output logic      busy,      // a beat is waiting
  output logic      free_nxt,  // empty, or empties with this pop
  output evt_beat_t head,
  output logic      head_last
);

  evt_beat_t        slot_r [NKIND];
  logic [NKIND-1:0] vld_r, vld_nxt;
  logic [NKIND-1:0] sel_oh;
  logic [1:0]       sel;

  always_comb begin
    sel    = 2'd0;
    sel_oh = 3'b001;
    if (vld_r[0]) begin
      sel = 2'd0; sel_oh = 3'b001;
    end else if (vld_r[1]) begin
      sel = 2'd1; sel_oh = 3'b010;
    end else begin
      sel = 2'd2; sel_oh = 3'b100;
    end
  end

  assign busy      = |vld_r;
  assign head      = slot_r[sel];
  assign head_last = ((vld_r & ~sel_oh) == '0);
  assign free_nxt  = !busy || (pop && head_last);

  always_comb begin
    vld_nxt = vld_r;
    if (pop) vld_nxt = vld_r & ~sel_oh;
    if (load) begin
      for (int k = 0; k < NKIND; k++) vld_nxt[k] = evt[k].fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < NKIND; k++) begin
        slot_r[k].kind      <= kind_t'(k);
        slot_r[k].count     <= evt[k].count;
        slot_r[k].idle_time <= evt[k].idle_time;
      end
    end
  end

endmodule

// ----- rtl/link_idle_detector.sv -----
// Top level of the link idle detector: idle-time counters, three timers, result buffer.
// Depends on lidl_pkg, lidl_timer and lidl_evbuf.
`timescale 1ns / 1ps
//
//  channel | dir | beat contents                                   | handshake
//  --------+-----+-------------------------------------------------+-----------------
//  in_     | in  | tdata: action[2:0], channel_open[3], zero fill  | tvalid/tready
//  out_    | out | tdata: idle_count[31:0], idle_time[63:32];      | tvalid/tready
//          |     | tuser: idle_kind; tlast: final event of a tick  |
//  cfg_    | in  | three 32-bit thresholds, index 0..2             | cfg_we, no wait
//
//  One input beat a cycle. A tick that raises n events (n up to 3) needs n
//  result beats; the next input beat is taken in the cycle the last of them
//  goes out, so the result port's single beat per cycle sets the figure.
//  Beats raising no event go straight through at one a cycle.
//  Synchronous active-low reset clears every counter, flag and threshold.
//  A stall on out_tready holds the buffered events and holds in_tready low.

module link_idle_detector
  import lidl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [2:0] action, [3] channel_open
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [63:0]         out_tdata,  // [31:0] idle_count, [63:32] idle_time
  output logic [KIND_W-1:0]   out_tuser,  // [1:0] idle_kind
  output logic                out_tlast,
  // configuration
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [THRESH_W-1:0] cfg_wdata
);

  logic                started_r, started_nxt;
  logic [TIME_W-1:0]   since_rd_r, since_rd_nxt;
  logic [TIME_W-1:0]   since_wr_r, since_wr_nxt;
  logic [TIME_W-1:0]   rd_inc, wr_inc;
  logic [THRESH_W-1:0] thresh_r [NKIND];
  logic [CMP_W-1:0]    elapsed [NKIND];
  tmr_ctl_t            ctl [NKIND];
  tmr_evt_t            evt [NKIND];
  action_t             act;
  logic                chan_open;
  logic                in_acc, out_acc;
  logic                is_tick, is_read, is_wdone, is_act, is_deact;
  logic                free_nxt;
  logic                busy;
  evt_beat_t           head;
  logic                head_last;

  assign act       = action_t'(in_tdata[2:0]);
  assign chan_open = in_tdata[3];
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign in_tready = free_nxt;

  // decode; codes 5..7 decode to nothing
  always_comb begin
    is_tick = 1'b0; is_read = 1'b0; is_wdone = 1'b0; is_act = 1'b0; is_deact = 1'b0;
    case (act)
      ACT_TICK:       is_tick  = in_acc;
      ACT_READ:       is_read  = in_acc;
      ACT_WRITE_DONE: is_wdone = in_acc;
      ACT_ACTIVATE:   is_act   = in_acc;
      ACT_DEACTIVATE: is_deact = in_acc;
      default:        ;
    endcase
  end

  // saturating idle-time counters
  assign rd_inc = (since_rd_r == '1) ? since_rd_r : since_rd_r + TIME_W'(1);
  assign wr_inc = (since_wr_r == '1) ? since_wr_r : since_wr_r + TIME_W'(1);

  always_comb begin
    started_nxt  = started_r;
    since_rd_nxt = since_rd_r;
    since_wr_nxt = since_wr_r;
    if (is_tick) begin
      since_rd_nxt = rd_inc;
      since_wr_nxt = wr_inc;
    end
    if (is_read)  since_rd_nxt = '0;
    if (is_wdone) since_wr_nxt = '0;
    if (is_act && !started_r) begin
      started_nxt  = 1'b1;
      since_rd_nxt = '0;
      since_wr_nxt = '0;
    end
  end

  // timers see the idle times as they stand after this tick
  assign elapsed[KIND_READER] = CMP_W'(rd_inc);
  assign elapsed[KIND_WRITER] = CMP_W'(wr_inc);
  assign elapsed[KIND_ALL]    = (rd_inc < wr_inc) ? CMP_W'(rd_inc) : CMP_W'(wr_inc);

  always_comb begin
    for (int k = 0; k < NKIND; k++) begin
      ctl[k].tick      = is_tick;
      ctl[k].arm       = is_act && !started_r;
      ctl[k].disarm    = is_deact;
      ctl[k].chan_open = chan_open;
      ctl[k].clr_count = 1'b0;
    end
    ctl[KIND_READER].clr_count = is_read;
    ctl[KIND_WRITER].clr_count = is_wdone;
    ctl[KIND_ALL].clr_count    = is_read || is_wdone;
  end

  genvar g;
  generate
    for (g = 0; g < NKIND; g++) begin : g_tmr
      lidl_timer u_tmr (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl[g]),
        .thresh  (thresh_r[g]),
        .elapsed (elapsed[g]),
        .evt     (evt[g])
      );
    end
  endgenerate

  lidl_evbuf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (is_tick),
    .evt       (evt),
    .pop       (out_acc),
    .busy      (busy),
    .free_nxt  (free_nxt),
    .head      (head),
    .head_last (head_last)
  );

  assign out_tvalid = busy;
  assign out_tdata  = {head.idle_time, head.count};
  assign out_tuser  = head.kind;
  assign out_tlast  = head_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      since_rd_r <= '0;
      since_wr_r <= '0;
    end else begin
      started_r  <= started_nxt;
      since_rd_r <= since_rd_nxt;
      since_wr_r <= since_wr_nxt;
    end
  end

  // thresholds; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NKIND; k++) thresh_r[k] <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_READER_IDLE: thresh_r[KIND_READER] <= cfg_wdata;
        REG_WRITER_IDLE: thresh_r[KIND_WRITER] <= cfg_wdata;
        REG_ALL_IDLE:    thresh_r[KIND_ALL]    <= cfg_wdata;
        default:         ;
      endcase
    end
  end

endmodule

// ----- rtl/lidl_checker.sv -----
// Port-level checks for link_idle_detector, bound to the top level.
// Depends on lidl_pkg.
`timescale 1ns / 1ps

module lidl_checker
  import lidl_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [63:0]       out_tdata,
  input logic [KIND_W-1:0] out_tuser,
  input logic              out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed under stall");

  // input is only taken with the buffer empty or draining its final beat
  a_in_gate: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && out_tvalid |-> out_tlast && out_tready)
    else $error("input taken while events still pending");

  // events of one tick come out in kind order
  a_kind_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && (out_tuser > $past(out_tuser)))
    else $error("event kinds out of order within a tick");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("unknown idle kind");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

bind link_idle_detector lidl_checker u_lidl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
